/* rtl/swpec_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// swpec_pkg
// Shared types and constants for the sliding window peak event counter.
// ----------------------------------------------------------------------------
package swpec_pkg;

   localparam int TIME_W   = 34;
   localparam int WIN_W    = 31;
   localparam int COUNT_W  = 11;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 34;

   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_START   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_END     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LENGTH = 2'd2;

   typedef logic [TIME_W-1:0]  time_type;
   typedef logic [WIN_W-1:0]   win_type;
   typedef logic [COUNT_W-1:0] count_type;

   // controller to datapath
   typedef struct packed {
      logic take;
      logic push;
      logic pop;
      logic load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic in_range;
      logic full;
      logic empty;
      logic pop_due;
      logic slot_free;
   } stat_type;

endpackage
`default_nettype wire

/* rtl/swpec_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// swpec request and response channels
// Valid/ready channels carrying the event timestamp and the window result.
// ----------------------------------------------------------------------------
interface swpec_req_if;
   import swpec_pkg::*;

   logic     valid;
   logic     ready;
   time_type event_time;

   modport source (output valid, output event_time, input ready);
   modport sink   (input valid, input event_time, output ready);
endinterface

interface swpec_rsp_if;
   import swpec_pkg::*;

   logic      valid;
   logic      ready;
   logic      accepted;
   logic      dropped_full;
   count_type window_count;
   count_type peak_count;

   modport source (output valid, output accepted, output dropped_full,
                   output window_count, output peak_count, input ready);
   modport sink   (input valid, input accepted, input dropped_full,
                   input window_count, input peak_count, output ready);
endinterface
`default_nettype wire

/* rtl/sliding_window_peak_event_count.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_peak_event_count
// Counts events inside a sliding time window and tracks the peak count.
// Requests are taken only while the sequencer is idle. A request stored into a
// non-empty window passes through the check state, which pops expired entries,
// before the finish state; other requests go straight to the finish state,
// which loads the response register once the previous response has left it.
// The pop loop reads one ring buffer entry per cycle through a single
// registered read port.
// Reset: synchronous, clears pointers, counts, peak and response valid and sets
// full range, zero window; the timestamp store is not cleared and needs none.
// ----------------------------------------------------------------------------
module sliding_window_peak_event_count #(
   parameter int STORE_DEPTH = 1024
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write,
   input  wire logic [swpec_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [swpec_pkg::CSR_DATA_W-1:0]  csr_data,
   swpec_req_if.sink                              req_ch,
   swpec_rsp_if.source                            rsp_ch
);
   import swpec_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     req_ready;

   assign req_ch.ready = req_ready;

   swpec_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   swpec_dp #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_event_time   (req_ch.event_time),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_accepted     (rsp_ch.accepted),
      .rsp_dropped_full (rsp_ch.dropped_full),
      .rsp_window_count (rsp_ch.window_count),
      .rsp_peak_count   (rsp_ch.peak_count)
   );

endmodule
`default_nettype wire

/* rtl/swpec_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// swpec_ctrl
// Sequencer: takes a request, runs the pop loop, hands off the response.
// ----------------------------------------------------------------------------
module swpec_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire swpec_pkg::stat_type stat,
   output swpec_pkg::cmd_type      cmd
);
   import swpec_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CHECK = 2'd1;
   localparam logic [1:0] S_FIN   = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       take;
   logic       push;

   assign req_ready = (state_ff == S_IDLE);
   assign take      = req_ready && req_valid;
   assign push      = take && stat.in_range && !stat.full;

   always_comb begin
      cmd.take = take;
      cmd.push = push;
      cmd.pop  = (state_ff == S_CHECK) && stat.pop_due;
      cmd.load = (state_ff == S_FIN) && stat.slot_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               // first push into an empty store never pops
               state_in = (push && !stat.empty) ? S_CHECK : S_FIN;
            end
         end
         S_CHECK: begin
            if (!stat.pop_due) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (stat.slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/swpec_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// swpec_dp
// Datapath: config registers, timestamp ring buffer, counts, response register.
// ----------------------------------------------------------------------------
module swpec_dp #(
   parameter int STORE_DEPTH = 1024
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write,
   input  wire logic [swpec_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [swpec_pkg::CSR_DATA_W-1:0]   csr_data,
   input  wire swpec_pkg::time_type                req_event_time,
   input  wire swpec_pkg::cmd_type                 cmd,
   output swpec_pkg::stat_type                     stat,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_accepted,
   output logic                                    rsp_dropped_full,
   output swpec_pkg::count_type                    rsp_window_count,
   output swpec_pkg::count_type                    rsp_peak_count
);
   import swpec_pkg::*;

   localparam int PTR_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CNT_MIN = $clog2(STORE_DEPTH + 1);
   localparam int CNT_W  = (CNT_MIN > COUNT_W) ? CNT_MIN : COUNT_W;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(STORE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STORE_DEPTH);

   time_type range_start_ff;
   time_type range_end_ff;
   win_type  window_length_ff;

   time_type time_store [STORE_DEPTH];
   time_type oldest_ff;
   time_type newest_ff;

   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff;
   logic [PTR_W-1:0] head_next;
   logic [PTR_W-1:0] tail_next;
   logic [CNT_W-1:0] held_ff, held_in;
   logic [CNT_W-1:0] peak_ff, peak_in;
   logic             acc_ff;
   logic             drop_ff;
   logic             rsp_valid_ff;
   logic             acc_out_ff;
   logic             drop_out_ff;
   count_type        win_out_ff;
   count_type        peak_out_ff;
   time_type         span;

   // config
   always_ff @(posedge clock) begin
      if (reset) begin
         range_start_ff   <= '0;
         range_end_ff     <= '1;
         window_length_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_RANGE_START:   range_start_ff   <= csr_data[TIME_W-1:0];
            CSR_RANGE_END:     range_end_ff     <= csr_data[TIME_W-1:0];
            CSR_WINDOW_LENGTH: window_length_ff <= csr_data[WIN_W-1:0];
            default: ;
         endcase
      end
   end

   assign head_next = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;
   assign head_in   = cmd.pop ? head_next : head_ff;

   always_comb begin
      held_in = held_ff;
      if (cmd.push) begin
         held_in = held_ff + 1'b1;
      end else if (cmd.pop) begin
         held_in = held_ff - 1'b1;
      end
   end

   assign peak_in = (held_ff > peak_ff) ? held_ff : peak_ff;

   // ring buffer, registered read of the oldest entry
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         time_store[tail_ff] <= req_event_time;
      end
      oldest_ff <= time_store[head_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         held_ff <= '0;
         peak_ff <= '0;
      end else begin
         head_ff <= head_in;
         held_ff <= held_in;
         if (cmd.push) begin
            tail_ff <= tail_next;
         end
         if (cmd.load) begin
            peak_ff <= peak_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         newest_ff <= req_event_time;
         acc_ff    <= stat.in_range && !stat.full;
         drop_ff   <= stat.in_range && stat.full;
      end
   end

   assign span = (newest_ff > oldest_ff) ? (newest_ff - oldest_ff) : '0;

   always_comb begin
      stat.in_range  = (req_event_time >= range_start_ff) &&
                       (req_event_time <= range_end_ff);
      stat.full      = (held_ff >= CNT_FULL);
      stat.empty     = (held_ff == '0);
      stat.pop_due   = (span > TIME_W'(window_length_ff));
      stat.slot_free = !rsp_valid_ff || rsp_ready;
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         acc_out_ff  <= acc_ff;
         drop_out_ff <= drop_ff;
         win_out_ff  <= held_ff[COUNT_W-1:0];
         peak_out_ff <= peak_in[COUNT_W-1:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accepted     = acc_out_ff;
   assign rsp_dropped_full = drop_out_ff;
   assign rsp_window_count = win_out_ff;
   assign rsp_peak_count   = peak_out_ff;

endmodule
`default_nettype wire

/* tb/sliding_window_peak_event_count_tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_peak_event_count_tb
// Drives event timestamps into the window counter and compares every response
// against a queue-based model of the window: directed corner cases, randomized
// streams with some out-of-order times under several range and window settings,
// sender and receiver idling, a long response hold-off, and a short burst.
// ----------------------------------------------------------------------------
module sliding_window_peak_event_count_tb;
   import swpec_pkg::*;

   localparam int STORE_DEPTH = 1024;
   localparam int HOLD_CYCLES = 300;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam time_type TIME_MAX = '1;

   typedef struct {
      time_type  event_time;
      logic      accepted;
      logic      dropped_full;
      count_type window_count;
      count_type peak_count;
   } window_result_type;

   class window_scoreboard;
      time_type          range_lo;
      time_type          range_hi;
      win_type           span_limit;
      int unsigned       depth;
      time_type          held_times[$];
      int unsigned       peak_held;
      window_result_type expected[$];
      int                mismatches;

      function new(int unsigned store_depth);
         depth      = store_depth;
         range_lo   = '0;
         range_hi   = '1;
         span_limit = '0;
         peak_held  = 0;
         mismatches = 0;
      endfunction

      task report_mismatch(string what);
         $display("mismatch: %s", what);
         mismatches++;
      endtask

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_RANGE_START:   range_lo = data[TIME_W-1:0];
            CSR_RANGE_END:     range_hi = data[TIME_W-1:0];
            CSR_WINDOW_LENGTH: span_limit = data[WIN_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_request(time_type t);
         window_result_type r;
         time_type          span;
         r.event_time   = t;
         r.accepted     = 1'b0;
         r.dropped_full = 1'b0;
         if (t >= range_lo && t <= range_hi) begin
            if (held_times.size() >= depth) begin
               r.dropped_full = 1'b1;
            end else begin
               r.accepted = 1'b1;
               held_times.push_back(t);
               // expire from the oldest end; a late timestamp counts as zero span
               while (held_times.size() > 0) begin
                  span = (t > held_times[0]) ? t - held_times[0] : '0;
                  if (span <= span_limit)
                     break;
                  void'(held_times.pop_front());
               end
               if (held_times.size() > peak_held)
                  peak_held = held_times.size();
            end
         end
         r.window_count = count_type'(held_times.size());
         r.peak_count   = count_type'(peak_held);
         expected.push_back(r);
      endfunction

      task check_response(logic acc, logic drop, count_type wc, count_type pc);
         window_result_type r;
         if (expected.size() == 0) begin
            report_mismatch("response with no request outstanding");
            return;
         end
         r = expected.pop_front();
         if (acc !== r.accepted)
            report_mismatch($sformatf("event %0d accepted %b, expected %b",
                                      r.event_time, acc, r.accepted));
         if (drop !== r.dropped_full)
            report_mismatch($sformatf("event %0d dropped_full %b, expected %b",
                                      r.event_time, drop, r.dropped_full));
         if (wc !== r.window_count)
            report_mismatch($sformatf("event %0d window_count %0d, expected %0d",
                                      r.event_time, wc, r.window_count));
         if (pc !== r.peak_count)
            report_mismatch($sformatf("event %0d peak_count %0d, expected %0d",
                                      r.event_time, pc, r.peak_count));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   int                    idle_pct = 0;
   int                    stall_pct = 0;
   int                    hold_requests = 0;

   window_scoreboard sb = new(STORE_DEPTH);

   swpec_req_if req_ch ();
   swpec_rsp_if rsp_ch ();

   sliding_window_peak_event_count #(
      .STORE_DEPTH (STORE_DEPTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   always #4 clock = ~clock;

   function automatic time_type clamp_time(logic [39:0] v);
      return (v > 40'(TIME_MAX)) ? TIME_MAX : v[TIME_W-1:0];
   endfunction

   task automatic drive_request(time_type t);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.event_time <= t;
      do
         @(posedge clock);
      while (!req_ch.ready);
      sb.note_request(t);
   endtask

   // leaves csr_write high; configure lowers it after the last write
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      sb.write_register(idx, data);
   endtask

   task automatic configure(time_type lo, time_type hi, logic [CSR_DATA_W-1:0] win_data);
      write_csr(CSR_RANGE_START, lo);
      write_csr(CSR_RANGE_END, hi);
      write_csr(CSR_WINDOW_LENGTH, win_data);
      csr_write <= 1'b0;
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (sb.expected.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic set_idling(int mode);
      case (mode)
         0: begin
            idle_pct  = 0;
            stall_pct = 0;
         end
         1: begin
            idle_pct  = 69;
            stall_pct = 0;
         end
         2: begin
            idle_pct  = 0;
            stall_pct = 69;
         end
         default: begin
            idle_pct  = 29;
            stall_pct = 29;
         end
      endcase
   endtask

   task automatic random_phase(int n_items, int mode, bit with_hold);
      win_type     window;
      int unsigned scale;
      time_type    base;
      time_type    now_t;
      time_type    t_item;
      time_type    lo;
      time_type    hi;
      logic [39:0] ext;
      int unsigned d;
      int          k;
      case ($urandom_range(3))
         0:       window = '0;
         1:       window = win_type'($urandom_range(1, 16));
         2:       window = win_type'($urandom);
         default: window = '1;
      endcase
      scale = 32'(window >> $urandom_range(5));
      if (scale == 0)
         scale = 1;
      base = time_type'({$urandom, $urandom});
      ext  = 40'(n_items) * 40'(scale);
      lo   = '0;
      hi   = TIME_MAX;
      case ($urandom_range(7))
         3, 4: begin
            lo = clamp_time(40'(base) + ext / 8);
            hi = clamp_time(40'(base) + ext * 3 / 4);
         end
         5: hi = clamp_time(40'(base) + ext / 2);
         6: lo = clamp_time(40'(base) + ext / 4);
         7: begin
            // empty range
            hi = base;
            lo = clamp_time(40'(base) + ext / 2 + 1);
         end
         default: ;
      endcase
      configure(lo, hi, CSR_DATA_W'({3'($urandom_range(7)), window}));
      set_idling(mode);
      if (with_hold)
         hold_requests++;
      now_t = base;
      for (int i = 0; i < n_items; i++) begin
         k = $urandom_range(99);
         d = $urandom_range(scale);
         if (k < 60) begin
            now_t  = clamp_time(40'(now_t) + 40'(d));
            t_item = now_t;
         end else if (k < 72) begin
            t_item = now_t;
         end else if (k < 82) begin
            now_t  = clamp_time(40'(now_t) + 40'(window) + 40'(d) + 1);
            t_item = now_t;
         end else if (k < 90) begin
            // out of order
            t_item = (now_t > time_type'(d)) ? now_t - time_type'(d) : '0;
         end else begin
            t_item = time_type'({$urandom, $urandom});
         end
         drive_request(t_item);
      end
      wait_drained();
   endtask

   initial begin : response_sink
      int holds_served;
      int hold_left;
      holds_served = 0;
      hold_left    = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready)
            sb.check_response(rsp_ch.accepted, rsp_ch.dropped_full,
                              rsp_ch.window_count, rsp_ch.peak_count);
         if (holds_served != hold_requests) begin
            hold_left = HOLD_CYCLES;
            holds_served++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   initial begin : stimulus
      time_type now_t;
      reset             = 1'b1;
      csr_write         = 1'b0;
      csr_index         = '0;
      csr_data          = '0;
      req_ch.valid      = 1'b0;
      req_ch.event_time = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset settings: full range, zero window
      drive_request('0);
      drive_request('0);
      drive_request(34'd1);
      drive_request(TIME_MAX);
      drive_request(34'd5);
      wait_drained();

      // narrow range, widest window with upper data bits set
      configure(34'd100, 34'd200, '1);
      drive_request(34'd99);
      drive_request(34'd100);
      drive_request(34'd150);
      drive_request(34'd200);
      drive_request(34'd201);
      wait_drained();

      // unused index, then an empty range
      write_csr(CSR_UNUSED, CSR_DATA_W'({$urandom, $urandom}));
      configure(TIME_MAX, '0, 34'd3);
      drive_request('0);
      drive_request(TIME_MAX);
      drive_request(34'd12345);
      wait_drained();

      configure('0, TIME_MAX, 34'd3);
      drive_request(34'd1000);
      drive_request(34'd1001);
      drive_request(34'd1003);
      drive_request(34'd1004);
      drive_request(34'd1010);
      drive_request(TIME_MAX);
      wait_drained();

      for (int p = 0; p < 12; p++)
         random_phase(40, p % 4, p == 6);

      // short burst of close timestamps under the widest window
      configure('0, TIME_MAX, '1);
      set_idling(3);
      now_t = time_type'({$urandom, $urandom});
      for (int i = 0; i < 12; i++) begin
         now_t = clamp_time(40'(now_t) + 40'($urandom_range(1)));
         drive_request(now_t);
      end
      wait_drained();

      configure('0, TIME_MAX, '0);
      drive_request(clamp_time(40'(now_t) + 40'd100));
      drive_request('0);
      drive_request(TIME_MAX);
      wait_drained();

      configure(TIME_MAX, '0, '0);
      drive_request(now_t);
      drive_request(TIME_MAX);
      wait_drained();

      repeat (20) @(posedge clock);
      if (sb.expected.size() != 0)
         sb.report_mismatch($sformatf("%0d responses never arrived", sb.expected.size()));
      if (sb.mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin : watchdog
      #4000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
`default_nettype wire

/* sliding_window_peak_event_count.f */
rtl/swpec_pkg.sv
rtl/swpec_if.sv
rtl/swpec_ctrl.sv
rtl/swpec_dp.sv
rtl/sliding_window_peak_event_count.sv
tb/sliding_window_peak_event_count_tb.sv
